// ===== rtl/core/pese_pkg.sv =====
// Shared types, codes and character constants for the prefix expression evaluator.
`timescale 1ns / 1ps
`default_nettype none
package pese_pkg;

    localparam int DefStackDepth = 64;

    localparam logic [7:0] ChPlus  = 8'h2B;
    localparam logic [7:0] ChMinus = 8'h2D;
    localparam logic [7:0] ChMul   = 8'h2A;
    localparam logic [7:0] ChDiv   = 8'h2F;
    localparam logic [7:0] ChMod   = 8'h25;
    localparam logic [7:0] ChPow   = 8'h5E;
    localparam logic [7:0] ChSpace = 8'h20;
    localparam logic [7:0] ChZero  = 8'h30;

    localparam logic [1:0] StOk        = 2'd0;
    localparam logic [1:0] StUnderflow = 2'd1;
    localparam logic [1:0] StOverflow  = 2'd2;
    localparam logic [1:0] StZero      = 2'd3;

    typedef enum logic [1:0] {
        AluDiv,
        AluMod,
        AluPow
    } alu_op_t;

    // Request to the iterative arithmetic unit.
    typedef struct packed {
        logic        start;
        alu_op_t     op;
    } alu_req_t;

    // Response of the iterative arithmetic unit.
    typedef struct packed {
        logic        done;
        logic        zero_err;
    } alu_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/pese_alu.sv =====
// Iterative divide, modulo and power unit; division yields one quotient bit per cycle, power uses square-and-multiply.
`timescale 1ns / 1ps
`default_nettype none
module pese_alu
    import pese_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire alu_req_t    req,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output alu_rsp_t         rsp,
    output logic [31:0]      result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_POW_MUL,
        S_POW_SQ
    } state_t;

    state_t      state_reg;
    alu_op_t     op_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] quo_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvs_reg;
    logic        neg_q_reg;
    logic        neg_r_reg;
    logic [31:0] acc_reg;
    logic [31:0] sq_reg;
    logic [31:0] exp_reg;
    logic        done_reg;
    logic        zero_reg;
    logic [31:0] result_reg;

    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [32:0] trial;
    logic [31:0] rem_shift;

    assign mag_a = a[31] ? (32'd0 - a) : a;
    assign mag_b = b[31] ? (32'd0 - b) : b;
    assign rem_shift = {rem_reg[30:0], quo_reg[31]};
    assign trial = {1'b0, rem_shift} - {1'b0, dvs_reg};

    assign rsp.done = done_reg;
    assign rsp.zero_err = zero_reg;
    assign result = result_reg;

    // Sequencer: restoring division or square-and-multiply, one step a cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.start)
                    begin
                        op_reg    <= req.op;
                        cnt_reg   <= 6'd0;
                        quo_reg   <= mag_a;
                        rem_reg   <= 32'd0;
                        dvs_reg   <= mag_b;
                        neg_q_reg <= a[31] ^ b[31];
                        neg_r_reg <= a[31];
                        acc_reg   <= 32'd1;
                        sq_reg    <= a;
                        exp_reg   <= b;
                        if (req.op == AluPow)
                        begin
                            if (b[31])
                            begin
                                done_reg <= 1'b1;
                                if (a == 32'd1)
                                    result_reg <= 32'd1;
                                else if (a == 32'hFFFF_FFFF)
                                    result_reg <= b[0] ? 32'hFFFF_FFFF : 32'd1;
                                else
                                    result_reg <= 32'd0;
                                zero_reg <= (a == 32'd0);
                            end
                            else
                            begin
                                done_reg  <= 1'b0;
                                zero_reg  <= 1'b0;
                                state_reg <= S_POW_MUL;
                            end
                        end
                        else if (b == 32'd0)
                        begin
                            done_reg   <= 1'b1;
                            zero_reg   <= 1'b1;
                            result_reg <= 32'd0;
                        end
                        else
                        begin
                            done_reg  <= 1'b0;
                            zero_reg  <= 1'b0;
                            state_reg <= S_DIV;
                        end
                    end
                    else
                        done_reg <= 1'b0;
                end
                S_DIV:
                begin
                    if (!trial[32])
                        rem_reg <= trial[31:0];
                    else
                        rem_reg <= rem_shift;
                    quo_reg <= {quo_reg[30:0], ~trial[32]};
                    cnt_reg <= cnt_reg + 6'd1;
                    done_reg <= (cnt_reg == 6'd31);
                    if (cnt_reg == 6'd31)
                    begin
                        state_reg <= S_IDLE;
                        if (op_reg == AluDiv)
                        begin
                            result_reg <= neg_q_reg
                                ? (32'd0 - {quo_reg[30:0], ~trial[32]})
                                : {quo_reg[30:0], ~trial[32]};
                        end
                        else
                        begin
                            result_reg <= neg_r_reg
                                ? (32'd0 - (trial[32] ? rem_shift : trial[31:0]))
                                : (trial[32] ? rem_shift : trial[31:0]);
                        end
                    end
                end
                S_POW_MUL:
                begin
                    if (exp_reg == 32'd0)
                    begin
                        state_reg  <= S_IDLE;
                        done_reg   <= 1'b1;
                        result_reg <= acc_reg;
                    end
                    else
                    begin
                        done_reg <= 1'b0;
                        if (exp_reg[0])
                            acc_reg <= acc_reg * sq_reg;
                        state_reg <= S_POW_SQ;
                    end
                end
                S_POW_SQ:
                begin
                    done_reg  <= 1'b0;
                    sq_reg    <= sq_reg * sq_reg;
                    exp_reg   <= {1'b0, exp_reg[31:1]};
                    state_reg <= S_POW_MUL;
                end
                default:
                begin
                    done_reg  <= 1'b0;
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/prefix_expression_stack_evaluator.sv =====
// Top level of the prefix expression evaluator: stack memory and control.
//
// Usage: characters of a prefix expression enter on the input channel
// (token, last), right to left. Digits and other bytes push (byte - 48)
// onto an operand stack held in a synchronous memory; + - * / % ^ pop two
// values and push the result; a space is skipped. On the transaction that
// carries last, one result transaction (value, status) is produced and the
// stack and error state are cleared.
// Steps: a push writes the memory directly; + - * read the second operand,
// then the top, then the second again, and then write the result. / and %
// run in the divider, one bit per cycle; ^ runs square-and-multiply with
// the multipliers of the arithmetic unit. On last, the top is read in the
// report states before the result transaction is produced.
// One item is processed at a time; in_ready is low while an item is at
// work. The result sits in an output register; while the receiver stalls,
// the next item is accepted and processed, and only a second report waits.
// Reset empties the stack and clears the error; memory contents are left
// as they are and are never used before being written.
`timescale 1ns / 1ps
`default_nettype none
module prefix_expression_stack_evaluator
    import pese_pkg::*;
#(
    parameter int STACK_DEPTH = DefStackDepth
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  token,
    input  wire logic        last,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      value,
    output logic [1:0]       status
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_B,
        S_WAIT_A,
        S_WAIT_B,
        S_EXEC,
        S_ALU,
        S_REPORT,
        S_REPORT_WAIT,
        S_OUT
    } state_t;

    state_t          state_reg;
    logic [DW-1:0]   depth_reg;
    logic [1:0]      err_reg;
    logic [7:0]      tok_reg;
    logic            last_reg;
    logic [31:0]     a_reg;
    logic [31:0]     rd_data_reg;
    logic            out_valid_reg;
    logic [31:0]     value_reg;
    logic [1:0]      status_reg;
    logic [31:0]     mem [STACK_DEPTH];

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [31:0]     mem_wdata;
    logic [AW-1:0]   mem_raddr;

    alu_req_t        alu_req;
    alu_rsp_t        alu_rsp;
    logic [31:0]     alu_result;
    logic            is_op;
    logic [DW-1:0]   dm1;
    logic [DW-1:0]   dm2;
    logic [31:0]     simple_res;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    assign dm1 = depth_reg - DW'(1);
    assign dm2 = depth_reg - DW'(2);

    assign is_op = (tok_reg == ChPlus) || (tok_reg == ChMinus) || (tok_reg == ChMul)
                || (tok_reg == ChDiv) || (tok_reg == ChMod) || (tok_reg == ChPow);

    // Add, subtract and multiply are computed combinationally.
    always_comb
    begin
        case (tok_reg)
            ChPlus:  simple_res = a_reg + rd_data_reg;
            ChMinus: simple_res = a_reg - rd_data_reg;
            default: simple_res = a_reg * rd_data_reg;
        endcase
    end

    // Operand stack memory, one write and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    // Memory addresses and write enable for each step.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = dm2[AW-1:0];
        mem_wdata = alu_result;
        mem_raddr = dm1[AW-1:0];
        alu_req.start = 1'b0;
        alu_req.op    = AluPow;
        if (tok_reg == ChDiv)
            alu_req.op = AluDiv;
        else if (tok_reg == ChMod)
            alu_req.op = AluMod;
        unique case (state_reg)
            S_RD_B:
            begin
                mem_raddr = dm2[AW-1:0];
                if (!is_op && tok_reg != ChSpace && depth_reg < DW'(STACK_DEPTH))
                begin
                    mem_we    = 1'b1;
                    mem_waddr = depth_reg[AW-1:0];
                    mem_wdata = 32'(tok_reg) - 32'(ChZero);
                end
            end
            S_WAIT_B:
                mem_raddr = dm2[AW-1:0];
            S_EXEC:
            begin
                if (tok_reg == ChPlus || tok_reg == ChMinus || tok_reg == ChMul)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = simple_res;
                end
                else
                    alu_req.start = 1'b1;
            end
            S_ALU:
                mem_we = alu_rsp.done;
            default:
            begin
            end
        endcase
    end

    pese_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (a_reg),
        .b      (rd_data_reg),
        .rsp    (alu_rsp),
        .result (alu_result)
    );

    // Control sequencer with depth, error and output registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            err_reg       <= StOk;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != S_OUT)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        tok_reg   <= token;
                        last_reg  <= last;
                        state_reg <= S_RD_B;
                    end
                end
                S_RD_B:
                begin
                    // The second operand is read this cycle; the top follows, then
                    // the second again so that it sits on the read port at execution.
                    if (tok_reg == ChSpace)
                        state_reg <= last_reg ? S_REPORT : S_IDLE;
                    else if (is_op)
                    begin
                        if (depth_reg < DW'(2))
                        begin
                            if (err_reg == StOk)
                                err_reg <= StUnderflow;
                            state_reg <= last_reg ? S_REPORT : S_IDLE;
                        end
                        else
                            state_reg <= S_WAIT_A;
                    end
                    else
                    begin
                        if (depth_reg < DW'(STACK_DEPTH))
                            depth_reg <= depth_reg + DW'(1);
                        else if (err_reg == StOk)
                            err_reg <= StOverflow;
                        state_reg <= last_reg ? S_REPORT : S_IDLE;
                    end
                end
                S_WAIT_A:
                begin
                    state_reg <= S_WAIT_B;
                end
                S_WAIT_B:
                begin
                    a_reg     <= rd_data_reg;
                    state_reg <= S_EXEC;
                end
                S_EXEC:
                begin
                    if (tok_reg == ChPlus || tok_reg == ChMinus || tok_reg == ChMul)
                    begin
                        depth_reg <= dm1;
                        state_reg <= last_reg ? S_REPORT : S_IDLE;
                    end
                    else
                        state_reg <= S_ALU;
                end
                S_ALU:
                begin
                    if (alu_rsp.done)
                    begin
                        depth_reg <= dm1;
                        if (alu_rsp.zero_err && err_reg == StOk)
                            err_reg <= StZero;
                        state_reg <= last_reg ? S_REPORT : S_IDLE;
                    end
                end
                S_REPORT:
                begin
                    state_reg <= S_REPORT_WAIT;
                end
                S_REPORT_WAIT:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        if (depth_reg == '0)
                        begin
                            value_reg  <= 32'd0;
                            status_reg <= (err_reg == StOk) ? StUnderflow : err_reg;
                        end
                        else
                        begin
                            value_reg  <= rd_data_reg;
                            status_reg <= err_reg;
                        end
                        depth_reg <= '0;
                        err_reg   <= StOk;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for the prefix expression stack evaluator.
`timescale 1ns / 1ps
module tb;
    import pese_pkg::*;

    localparam int Depth      = DefStackDepth;
    localparam int CycleLimit = 1500000;

    // One row of the directed table; a typed-in expectation applies on last rows.
    typedef struct {
        logic [7:0]  tok;
        logic        fin;
        logic        typed;
        logic [31:0] val;
        logic [1:0]  st;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  token;
    logic        last;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] value;
    logic [1:0]  status;

    // Predictor state.
    logic [31:0] calc_stack [Depth];
    int          calc_depth;
    logic [1:0]  calc_err;

    // Reports that are waiting to come out of the block.
    logic [31:0] report_vals [$];
    logic [1:0]  report_codes [$];

    int   fail_count;
    int   cycle_count;
    row_t dir_rows [$];

    prefix_expression_stack_evaluator DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .token(token), .last(last),
        .out_valid(out_valid), .out_ready(out_ready), .value(value), .status(status)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("Mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic void keep_first_error(input logic [1:0] code);
        if (calc_err == StOk)
            calc_err = code;
    endfunction

    function automatic logic [31:0] magn(input logic [31:0] v);
        return v[31] ? -v : v;
    endfunction

    function automatic logic [31:0] raise_power(input logic [31:0] base, input logic [31:0] ex);
        logic [31:0] acc;
        logic [31:0] sq;
        acc = 32'd1;
        sq = base;
        if (ex[31])
        begin
            if (base == 32'd1)
                return 32'd1;
            if (base == 32'hFFFF_FFFF)
                return ex[0] ? 32'hFFFF_FFFF : 32'd1;
            if (base == 32'd0)
                keep_first_error(StZero);
            return 32'd0;
        end
        while (ex != 0)
        begin
            if (ex[0])
                acc = acc * sq;
            sq = sq * sq;
            ex = ex >> 1;
        end
        return acc;
    endfunction

    function automatic logic [31:0] combine(input logic [7:0] op, input logic [31:0] a,
                                            input logic [31:0] b);
        logic [31:0] q;
        logic [31:0] r;
        case (op)
            ChPlus:  return a + b;
            ChMinus: return a - b;
            ChMul:   return a * b;
            ChPow:   return raise_power(a, b);
            default: ;
        endcase
        if (b == 0)
        begin
            keep_first_error(StZero);
            return 32'd0;
        end
        q = magn(a) / magn(b);
        r = magn(a) % magn(b);
        if (op == ChDiv)
            return (a[31] != b[31]) ? -q : q;
        return a[31] ? -r : r;
    endfunction

    function automatic logic is_op(input logic [7:0] t);
        return t == ChPlus || t == ChMinus || t == ChMul || t == ChDiv || t == ChMod
            || t == ChPow;
    endfunction

    // Advance the predictor by one accepted transaction; queue a report on last.
    function automatic void evaluate_char(input logic [7:0] t, input logic fin);
        logic [31:0] top;
        if (t == ChSpace)
            ;
        else if (is_op(t))
        begin
            if (calc_depth < 2)
                keep_first_error(StUnderflow);
            else
            begin
                calc_stack[calc_depth-2] = combine(t, calc_stack[calc_depth-1],
                                                   calc_stack[calc_depth-2]);
                calc_depth--;
            end
        end
        else if (calc_depth >= Depth)
            keep_first_error(StOverflow);
        else
        begin
            calc_stack[calc_depth] = {24'd0, t} - 32'd48;
            calc_depth++;
        end
        if (fin)
        begin
            top = 32'd0;
            if (calc_depth == 0)
                keep_first_error(StUnderflow);
            else
                top = calc_stack[calc_depth-1];
            report_vals.push_back(top);
            report_codes.push_back(calc_err);
            calc_depth = 0;
            calc_err = StOk;
        end
    endfunction

    // Send one transaction, holding valid until it is accepted.
    task automatic send_char(input logic [7:0] t, input logic fin);
        in_valid <= 1'b1;
        token <= t;
        last <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        evaluate_char(t, fin);
        @(negedge clk);
    endtask

    // Random gap between bursts of the sender.
    task automatic maybe_gap(inout int burst);
        int gap;
        if (burst > 0)
        begin
            burst--;
            return;
        end
        gap = $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap)
                @(negedge clk);
        end
        burst = $urandom_range(0, 12);
    endtask

    function automatic logic [7:0] digit();
        return 8'h30 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] any_op();
        case ($urandom_range(0, 5))
            0: return ChPlus;
            1: return ChMinus;
            2: return ChMul;
            3: return ChDiv;
            4: return ChMod;
            default: return ChPow;
        endcase
    endfunction

    function automatic void add_row(input logic [7:0] t, input logic f, input logic ty,
                                    input logic [31:0] v, input logic [1:0] s);
        row_t r;
        r.tok = t;
        r.fin = f;
        r.typed = ty;
        r.val = v;
        r.st = s;
        dir_rows.push_back(r);
    endfunction

    // Receiver stalls on a pattern that drifts through quiet and busy stretches.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (cycle_count % 600 < 150)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 99) < 60);
    end

    // Check each result transaction against the oldest pending report.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (out_valid && out_ready)
            begin
                if (report_vals.size() == 0)
                    report_mismatch("unexpected result", value, 32'hx);
                else
                begin
                    if (value !== report_vals[0])
                        report_mismatch("value", value, report_vals[0]);
                    if (status !== report_codes[0])
                        report_mismatch("status", 32'(status), 32'(report_codes[0]));
                    void'(report_vals.pop_front());
                    void'(report_codes.pop_front());
                end
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        if (cycle_count > CycleLimit)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        int burst;
        int n;
        int len;
        int kind;
        rst_n = 1'b0;
        in_valid = 1'b0;
        token = 8'd0;
        last = 1'b0;
        out_ready = 1'b0;
        fail_count = 0;
        cycle_count = 0;
        calc_depth = 0;
        calc_err = StOk;
        burst = 0;
        n = 0;

        // Directed table: extremes, every operator and each special case.
        add_row(ChZero, 1'b1, 1'b1, 32'd0, StOk);
        add_row(8'd255, 1'b1, 1'b1, 32'd207, StOk);
        add_row(8'd0, 1'b1, 1'b1, 32'hFFFF_FFD0, StOk);
        add_row(ChSpace, 1'b1, 1'b1, 32'd0, StUnderflow);
        add_row(ChPlus, 1'b1, 1'b1, 32'd0, StUnderflow);
        add_row("7", 1'b0, 1'b0, 32'd0, StOk);
        add_row("3", 1'b0, 1'b0, 32'd0, StOk);
        add_row(ChMinus, 1'b0, 1'b0, 32'd0, StOk);
        add_row(ChSpace, 1'b1, 1'b1, 32'hFFFF_FFFC, StOk);
        add_row(ChZero, 1'b0, 1'b0, 32'd0, StOk);
        add_row("5", 1'b0, 1'b0, 32'd0, StOk);
        add_row(ChDiv, 1'b1, 1'b1, 32'd0, StZero);
        add_row(ChZero, 1'b0, 1'b0, 32'd0, StOk);
        add_row("5", 1'b0, 1'b0, 32'd0, StOk);
        add_row(ChMod, 1'b1, 1'b1, 32'd0, StZero);
        add_row("!", 1'b0, 1'b0, 32'd0, StOk);
        add_row(ChZero, 1'b0, 1'b0, 32'd0, StOk);
        add_row(ChPow, 1'b1, 1'b1, 32'd0, StZero);
        add_row(ChZero, 1'b0, 1'b0, 32'd0, StOk);
        add_row(ChZero, 1'b0, 1'b0, 32'd0, StOk);
        add_row(ChPow, 1'b1, 1'b1, 32'd1, StOk);
        add_row("9", 1'b0, 1'b0, 32'd0, StOk);
        add_row("8", 1'b0, 1'b0, 32'd0, StOk);
        add_row(ChMul, 1'b1, 1'b0, 32'd0, StOk);

        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_rows[i])
        begin
            maybe_gap(burst);
            send_char(dir_rows[i].tok, dir_rows[i].fin);
            if (dir_rows[i].typed && dir_rows[i].fin)
            begin
                if (report_vals[$] !== dir_rows[i].val)
                    report_mismatch("table value", report_vals[$], dir_rows[i].val);
                if (report_codes[$] !== dir_rows[i].st)
                    report_mismatch("table status", 32'(report_codes[$]),
                                    32'(dir_rows[i].st));
            end
            n++;
        end

        // Overflow: fill past the stack depth with the most negative byte, then fold.
        for (int i = 0; i < Depth + 2; i++)
        begin
            maybe_gap(burst);
            send_char(8'd0, 1'b0);
        end
        send_char(ChMul, 1'b1);
        n += Depth + 3;

        // Most negative value divided by -1, and powers with negative exponents.
        for (int s = 0; s < 8; s++)
        begin
            // Build -1 as 0 - 1, then 2 ^ 31 on top of it.
            send_char("1", 1'b0);
            send_char(ChZero, 1'b0);
            send_char(ChMinus, 1'b0);
            send_char("O", 1'b0);
            send_char("2", 1'b0);
            send_char(ChPow, 1'b0);
            send_char(s[0] ? ChDiv : ChMod, 1'b1);
            // Exponent of -9 or -2 below a base of 0, 1, 2 or -1.
            send_char(s[0] ? 8'd39 : 8'd46, 1'b0);
            if (s[2:1] == 2'd3)
            begin
                send_char("1", 1'b0);
                send_char(ChZero, 1'b0);
                send_char(ChMinus, 1'b0);
            end
            else
                send_char(ChZero + 8'(s[2:1]), 1'b0);
            send_char(ChPow, 1'b1);
            n += (s[2:1] == 2'd3) ? 12 : 10;
        end

        // Random part: mostly well-formed expressions, some noise.
        while (n < 1250)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 7)
            begin
                len = (kind == 0) ? $urandom_range(2, 20) : $urandom_range(1, 5);
                for (int i = 0; i < len; i++)
                begin
                    maybe_gap(burst);
                    send_char(($urandom_range(0, 9) == 0) ? 8'($urandom) : digit(), 1'b0);
                    n++;
                    if ($urandom_range(0, 4) == 0)
                    begin
                        send_char(ChSpace, 1'b0);
                        n++;
                    end
                end
                for (int i = 1; i < len; i++)
                begin
                    maybe_gap(burst);
                    send_char(any_op(), i == len - 1);
                    n++;
                end
                if (len == 1)
                begin
                    send_char(ChSpace, 1'b1);
                    n++;
                end
            end
            else
            begin
                maybe_gap(burst);
                send_char(($urandom_range(0, 1) != 0) ? any_op() : 8'($urandom),
                          $urandom_range(0, 3) == 0);
                n++;
            end
        end
        send_char(ChSpace, 1'b1);
        in_valid <= 1'b0;

        while (report_vals.size() != 0)
            @(posedge clk);
        repeat (100)
            @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
